// ----- rtl/ptt_pkg.sv -----
// Shared constants for the periodic timer table: field widths, request codes
// and result status codes. Depends on nothing.
`default_nettype none

package ptt_pkg;

   localparam int KEY_BITS    = 16;
   localparam int PERIOD_BITS = 32;
   localparam int STATUS_BITS = 2;

   // Request kinds.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CHECK = 1'b1;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_NEW     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UPDATED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

endpackage : ptt_pkg

`default_nettype wire

// ----- rtl/ptt_cell.sv -----
// One timer slot of the rotating ring: valid bit, key, period and due time.
// Depends on ptt_pkg for the key and period widths.
`default_nettype none

module ptt_cell
   import ptt_pkg::*;
#(
   parameter int TICK_BITS = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift,
   input  wire logic                   in_valid,
   input  wire logic [KEY_BITS-1:0]    in_key,
   input  wire logic [PERIOD_BITS-1:0] in_period,
   input  wire logic [TICK_BITS-1:0]   in_due,
   output logic                        out_valid,
   output logic [KEY_BITS-1:0]         out_key,
   output logic [PERIOD_BITS-1:0]      out_period,
   output logic [TICK_BITS-1:0]        out_due
);

   logic                   valid_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [TICK_BITS-1:0]   due_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   // The payload moves with the valid bit and needs no reset.
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff    <= in_key;
         period_ff <= in_period;
         due_ff    <= in_due;
      end
   end

   assign out_valid  = valid_ff;
   assign out_key    = key_ff;
   assign out_period = period_ff;
   assign out_due    = due_ff;

endmodule : ptt_cell

`default_nettype wire

// ----- rtl/periodic_timer_table.sv -----
// Top level of the periodic timer table: the ring of slot cells and the head
// sequencer that serves add and check requests. Depends on ptt_pkg, ptt_cell.
`default_nettype none

// The table keeps up to TIMER_SLOTS periodic timers in insertion order, held
// in a ring of cells that rotates one slot per cycle past a single head unit
// while a request is served and no due timer must wait because the previous
// report still sits unaccepted on the result port. Each request takes one
// full turn of the ring, after which the final result is handed over to the
// result register as soon as that register is free. The next request is
// accepted in the cycle after the final result has been registered.
// An add request searches the turn for its key: a match gets the new period
// and is rescheduled to the current tick plus that period (status updated);
// without a match the entry is placed in the first unused slot and is due at
// once (status new); with no free slot the request is refused (status full).
// An add always gives exactly one result, marked last. A check request
// reports every valid timer whose due time is not later than the current
// tick, in slot order, and advances each of them by one period; the final
// report is marked last, and when nothing is due a single empty result marked
// last is returned. All time sums wrap modulo 2^TICK_BITS, and the due test
// is a plain unsigned compare. A new request is taken once the final result
// of the previous one has moved into the result register.

module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int TICK_BITS   = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_type,
   input  wire logic [KEY_BITS-1:0]    req_timer_key,
   input  wire logic [PERIOD_BITS-1:0] req_period,
   input  wire logic [TICK_BITS-1:0]   req_current_tick,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_fired,
   output logic [KEY_BITS-1:0]         rsp_fired_key,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic                        rsp_last
);

   // Step counter and fill count both need to hold TIMER_SLOTS itself.
   localparam int SW = $clog2(TIMER_SLOTS + 1);
   localparam logic [SW-1:0] SLOT_COUNT = SW'(TIMER_SLOTS);
   localparam int SUM_W = ((TICK_BITS > PERIOD_BITS) ? TICK_BITS : PERIOD_BITS) + 1;

   // Ring of cells. Cell 0 is the head; cell i takes the entry of cell i+1,
   // and the last cell takes the entry that leaves the head unit.
   logic                   ring_valid  [TIMER_SLOTS];
   logic [KEY_BITS-1:0]    ring_key    [TIMER_SLOTS];
   logic [PERIOD_BITS-1:0] ring_period [TIMER_SLOTS];
   logic [TICK_BITS-1:0]   ring_due    [TIMER_SLOTS];

   logic                   head_valid;
   logic [KEY_BITS-1:0]    head_key;
   logic [PERIOD_BITS-1:0] head_period;
   logic [TICK_BITS-1:0]   head_due;
   logic                   shift;

   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      if (i == TIMER_SLOTS - 1) begin : g_tail
         ptt_cell #(.TICK_BITS(TICK_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .in_valid   (head_valid),
            .in_key     (head_key),
            .in_period  (head_period),
            .in_due     (head_due),
            .out_valid  (ring_valid[i]),
            .out_key    (ring_key[i]),
            .out_period (ring_period[i]),
            .out_due    (ring_due[i])
         );
      end else begin : g_body
         ptt_cell #(.TICK_BITS(TICK_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .in_valid   (ring_valid[i+1]),
            .in_key     (ring_key[i+1]),
            .in_period  (ring_period[i+1]),
            .in_due     (ring_due[i+1]),
            .out_valid  (ring_valid[i]),
            .out_key    (ring_key[i]),
            .out_period (ring_period[i]),
            .out_due    (ring_due[i])
         );
      end
   end

   // Request being served.
   logic                   busy_ff, busy_in;
   logic                   op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [TICK_BITS-1:0]   now_ff;
   logic [SW-1:0]          step_ff, step_in;
   logic [SW-1:0]          used_ff, used_in;
   logic                   found_ff, found_in;
   logic                   appended_ff, appended_in;

   // A due timer waits here until the next one is found or the turn ends,
   // which decides whether it is the last report.
   logic                   pend_vld_ff, pend_vld_in;
   logic [KEY_BITS-1:0]    pend_key_ff, pend_key_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fired_ff, rsp_fired_in;
   logic [KEY_BITS-1:0]    rsp_key_ff, rsp_key_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic turning;
   logic final_step;
   logic key_match;
   logic due_now;
   logic fire;
   logic advance;
   logic [SUM_W-1:0] resched_sum;
   logic [SUM_W-1:0] advance_sum;

   assign req_ready  = !busy_ff;
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign turning    = busy_ff && (step_ff != SLOT_COUNT);
   assign final_step = busy_ff && (step_ff == SLOT_COUNT);

   assign key_match   = ring_valid[0] && (ring_key[0] == key_ff);
   assign due_now     = ring_valid[0] && (now_ff >= ring_due[0]);
   assign fire        = (op_ff == REQ_CHECK) && due_now;
   assign resched_sum = SUM_W'(now_ff) + SUM_W'(period_ff);
   assign advance_sum = SUM_W'(ring_due[0]) + SUM_W'(ring_period[0]);

   // A second due timer may only be found once the waiting one can leave.
   assign advance = !fire || !pend_vld_ff || out_free;
   assign shift   = turning && advance;

   // Head unit: the entry at cell 0 is updated on its way to the tail.
   always_comb begin
      head_valid  = ring_valid[0];
      head_key    = ring_key[0];
      head_period = ring_period[0];
      head_due    = ring_due[0];
      found_in    = found_ff;
      appended_in = appended_ff;
      used_in     = used_ff;
      if (op_ff == REQ_ADD) begin
         if (key_match) begin
            head_period = period_ff;
            head_due    = resched_sum[TICK_BITS-1:0];
            found_in    = 1'b1;
         end else if (!found_ff && !appended_ff && (step_ff == used_ff) &&
                      (used_ff != SLOT_COUNT)) begin
            // Slots are filled in order, so the search is complete here.
            head_valid  = 1'b1;
            head_key    = key_ff;
            head_period = period_ff;
            head_due    = now_ff;
            appended_in = 1'b1;
            used_in     = used_ff + SW'(1);
         end
      end else if (due_now) begin
         head_due = advance_sum[TICK_BITS-1:0];
      end
      if (!shift) begin
         found_in    = found_ff;
         appended_in = appended_ff;
         used_in     = used_ff;
      end
   end

   // Sequencer and result path.
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      pend_vld_in   = pend_vld_ff;
      pend_key_in   = pend_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         busy_in     = 1'b1;
         step_in     = '0;
         pend_vld_in = 1'b0;
      end else if (shift) begin
         step_in = step_ff + SW'(1);
         if (fire) begin
            if (pend_vld_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b1;
               rsp_key_in    = pend_key_ff;
               rsp_status_in = STATUS_NEW;
               rsp_last_in   = 1'b0;
            end
            pend_vld_in = 1'b1;
            pend_key_in = ring_key[0];
         end
      end else if (final_step && out_free) begin
         busy_in      = 1'b0;
         pend_vld_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         if (op_ff == REQ_ADD) begin
            rsp_fired_in = 1'b0;
            rsp_key_in   = '0;
            if (found_ff) begin
               rsp_status_in = STATUS_UPDATED;
            end else if (appended_ff) begin
               rsp_status_in = STATUS_NEW;
            end else begin
               rsp_status_in = STATUS_FULL;
            end
         end else begin
            rsp_fired_in  = pend_vld_ff;
            rsp_key_in    = pend_vld_ff ? pend_key_ff : '0;
            rsp_status_in = STATUS_NEW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         used_ff      <= '0;
         found_ff     <= 1'b0;
         appended_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         used_ff      <= used_in;
         found_ff     <= accept ? 1'b0 : found_in;
         appended_ff  <= accept ? 1'b0 : appended_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_type;
         key_ff    <= req_timer_key;
         period_ff <= req_period;
         now_ff    <= req_current_tick;
      end
      pend_key_ff   <= pend_key_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = rsp_fired_ff;
   assign rsp_fired_key = rsp_key_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // The fill count never passes the number of slots.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOT_COUNT)
      else $error("fill count exceeds the number of slots");

   // A waiting report only exists during a check request.
   a_pend_check: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (busy_ff && (op_ff == REQ_CHECK)))
      else $error("report waiting outside a check request");

   // Ending a turn always delivers a final result marked last.
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      (final_step && out_free) |=> (rsp_valid && rsp_last && !busy_ff))
      else $error("turn ended without a final result");

   // A result that reports no timer is always the final one with key zero.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> (rsp_last && (rsp_fired_key == '0)))
      else $error("empty result not marked last or key not zero");

endmodule : periodic_timer_table

`default_nettype wire
